// ===== src/gfp_pkg.sv =====
// Package with the types, codes and constants shared by the GOOSE frame parser modules.
`default_nettype none
package gfp_pkg;

   localparam int QueueDepth = 4;
   localparam logic [29:0] NsPerSec = 30'd1000000000;

   typedef enum logic [4:0] {
      PH_HDR      = 5'd0,
      PH_PDU_LEN  = 5'd1,
      PH_PDU_SKIP = 5'd2,
      PH_GOCB_LEN = 5'd3,
      PH_GOCB_CHR = 5'd4,
      PH_TAL      = 5'd5,
      PH_DS_LEN   = 5'd6,
      PH_DS_CHR   = 5'd7,
      PH_GOID_LEN = 5'd8,
      PH_GOID_CHR = 5'd9,
      PH_T_LEN    = 5'd10,
      PH_T_VAL    = 5'd11,
      PH_ST       = 5'd12,
      PH_SQ       = 5'd13,
      PH_TEST     = 5'd14,
      PH_CR       = 5'd15,
      PH_NDS      = 5'd16,
      PH_CNT      = 5'd17,
      PH_SET_LEN  = 5'd18,
      PH_SET_SKIP = 5'd19,
      PH_ENT_TYPE = 5'd20,
      PH_ENT_SIZE = 5'd21,
      PH_ENT_DATA = 5'd22,
      PH_DONE     = 5'd23
   } phase_type;

   localparam logic [4:0] FC_NONE     = 5'd0;
   localparam logic [4:0] FC_DST_MAC  = 5'd1;
   localparam logic [4:0] FC_SRC_MAC  = 5'd2;
   localparam logic [4:0] FC_TPID     = 5'd3;
   localparam logic [4:0] FC_GOCB_CHR = 5'd10;
   localparam logic [4:0] FC_TAL      = 5'd11;
   localparam logic [4:0] FC_DS_CHR   = 5'd12;
   localparam logic [4:0] FC_GOID_CHR = 5'd13;
   localparam logic [4:0] FC_TIME     = 5'd14;
   localparam logic [4:0] FC_STNUM    = 5'd15;
   localparam logic [4:0] FC_SQNUM    = 5'd16;
   localparam logic [4:0] FC_TEST     = 5'd17;
   localparam logic [4:0] FC_CONFREV  = 5'd18;
   localparam logic [4:0] FC_NDSCOM   = 5'd19;
   localparam logic [4:0] FC_ENT_CNT  = 5'd20;
   localparam logic [4:0] FC_ENT_TYPE = 5'd21;
   localparam logic [4:0] FC_ENT_SIZE = 5'd22;
   localparam logic [4:0] FC_ENT_BYTE = 5'd23;
   localparam logic [4:0] FC_MAX      = 5'd23;

   localparam logic [7:0] LenOneMore = 8'h81;
   localparam logic [7:0] LenTwoMore = 8'h82;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_last;
   } req_type;

   typedef struct packed {
      logic [4:0]  field_code;
      logic [61:0] field_value;
      logic [15:0] entry_number;
      logic [7:0]  byte_number;
      logic        frame_end;
      logic        parse_complete;
   } rsp_type;

   typedef struct packed {
      rsp_type     rsp;
      logic        is_time;
      logic [31:0] seconds;
      logic [31:0] fraction;
   } rec_type;

endpackage
`default_nettype wire

// ===== src/gfp_front.sv =====
// Byte-wise GOOSE field classifier that turns frame bytes into result records.
`default_nettype none
module gfp_front (
   input  wire               clock,
   input  wire               reset,
   input  wire               byte_valid,
   input  gfp_pkg::req_type  byte_data,
   output gfp_pkg::rec_type  rec,
   output logic              rec_push
);

   gfp_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  len_ff, len_in;
   logic [47:0] asm_ff, asm_in;
   logic [31:0] secs_ff, secs_in;
   logic [31:0] frac_ff, frac_in;
   logic [15:0] expect_ff, expect_in;
   logic [15:0] entry_ff, entry_in;
   logic        done_ff, done_in;

   logic [7:0]  b;
   logic [7:0]  c;
   logic        emit;
   logic [47:0] shifted;
   logic [15:0] int_word;
   logic [8:0]  c_next;
   logic [15:0] entry_inc;
   logic [1:0]  byte_lane;

   assign b = byte_data.frame_byte;
   assign c = count_ff;
   assign c_next = {1'b0, count_ff} + 9'd1;
   assign shifted = {asm_ff[39:0], b};
   assign int_word = {asm_ff[7:0], b};
   assign entry_inc = entry_ff + 16'd1;

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      len_in    = len_ff;
      asm_in    = asm_ff;
      secs_in   = secs_ff;
      frac_in   = frac_ff;
      expect_in = expect_ff;
      entry_in  = entry_ff;
      done_in   = done_ff;
      emit      = 1'b0;
      byte_lane = 2'd0;
      rec       = '0;
      case (phase_ff)
         gfp_pkg::PH_HDR: begin
            asm_in = shifted;
            if (c == 8'd5 || c == 8'd11) begin
               rec.rsp.field_code  = (c == 8'd5) ? gfp_pkg::FC_DST_MAC : gfp_pkg::FC_SRC_MAC;
               rec.rsp.field_value = {14'd0, shifted};
               emit = 1'b1;
               asm_in = '0;
            end else if (c >= 8'd13 && c <= 8'd25 && c[0]) begin
               rec.rsp.field_code  = gfp_pkg::FC_TPID + 5'((c - 8'd13) >> 1);
               rec.rsp.field_value = {46'd0, shifted[15:0]};
               emit = 1'b1;
               asm_in = '0;
            end
            if (c >= 8'd26) begin
               asm_in   = '0;
               phase_in = gfp_pkg::PH_PDU_LEN;
               count_in = '0;
            end else begin
               count_in = c_next[7:0];
            end
         end
         gfp_pkg::PH_PDU_LEN, gfp_pkg::PH_SET_LEN: begin
            if (b == gfp_pkg::LenOneMore) begin
               len_in = 8'd1;
            end else if (b == gfp_pkg::LenTwoMore) begin
               len_in = 8'd2;
            end else begin
               len_in = 8'd0;
            end
            if (phase_ff == gfp_pkg::PH_PDU_LEN) begin
               len_in   = len_in + 8'd1;
               phase_in = gfp_pkg::PH_PDU_SKIP;
            end else if (len_in == 8'd0) begin
               if (entry_ff >= expect_ff) begin
                  done_in  = 1'b1;
                  phase_in = gfp_pkg::PH_DONE;
               end else begin
                  phase_in = gfp_pkg::PH_ENT_TYPE;
               end
            end else begin
               phase_in = gfp_pkg::PH_SET_SKIP;
            end
            count_in = '0;
         end
         gfp_pkg::PH_PDU_SKIP, gfp_pkg::PH_SET_SKIP: begin
            count_in = c_next[7:0];
            if (c_next >= {1'b0, len_ff}) begin
               count_in = '0;
               if (phase_ff == gfp_pkg::PH_PDU_SKIP) begin
                  phase_in = gfp_pkg::PH_GOCB_LEN;
               end else if (entry_ff >= expect_ff) begin
                  done_in  = 1'b1;
                  phase_in = gfp_pkg::PH_DONE;
               end else begin
                  phase_in = gfp_pkg::PH_ENT_TYPE;
               end
            end
         end
         gfp_pkg::PH_GOCB_LEN, gfp_pkg::PH_DS_LEN, gfp_pkg::PH_GOID_LEN: begin
            len_in   = b;
            count_in = '0;
            phase_in = gfp_pkg::phase_type'(phase_ff + 5'd1);
         end
         gfp_pkg::PH_GOCB_CHR, gfp_pkg::PH_DS_CHR, gfp_pkg::PH_GOID_CHR: begin
            if (c < len_ff) begin
               if (phase_ff == gfp_pkg::PH_GOCB_CHR) begin
                  rec.rsp.field_code = gfp_pkg::FC_GOCB_CHR;
               end else if (phase_ff == gfp_pkg::PH_DS_CHR) begin
                  rec.rsp.field_code = gfp_pkg::FC_DS_CHR;
               end else begin
                  rec.rsp.field_code = gfp_pkg::FC_GOID_CHR;
               end
               rec.rsp.field_value = {54'd0, b};
               rec.rsp.byte_number = c;
               emit     = 1'b1;
               count_in = c_next[7:0];
            end else begin
               count_in = '0;
               phase_in = gfp_pkg::phase_type'(phase_ff + 5'd1);
            end
         end
         gfp_pkg::PH_T_LEN: begin
            len_in   = b;
            count_in = '0;
            secs_in  = '0;
            frac_in  = '0;
            if (b == 8'd0) begin
               rec.rsp.field_code = gfp_pkg::FC_TIME;
               rec.is_time = 1'b1;
               emit = 1'b1;
            end
            phase_in = gfp_pkg::PH_T_VAL;
         end
         gfp_pkg::PH_T_VAL: begin
            if (c < len_ff) begin
               case (c[1:0])
                  2'd0: byte_lane = 2'd3;
                  2'd1: byte_lane = 2'd2;
                  2'd2: byte_lane = 2'd1;
                  default: byte_lane = 2'd0;
               endcase
               if (c < 8'd4) begin
                  secs_in = secs_ff | (32'(b) << {byte_lane, 3'b000});
               end else if (c < 8'd8) begin
                  frac_in = frac_ff | (32'(b) << {byte_lane, 3'b000});
               end
               if (c_next == {1'b0, len_ff}) begin
                  rec.rsp.field_code = gfp_pkg::FC_TIME;
                  rec.is_time  = 1'b1;
                  rec.seconds  = secs_in;
                  rec.fraction = frac_in;
                  emit = 1'b1;
               end
               count_in = c_next[7:0];
            end else begin
               count_in = '0;
               phase_in = gfp_pkg::PH_ST;
            end
         end
         gfp_pkg::PH_TAL, gfp_pkg::PH_ST, gfp_pkg::PH_SQ, gfp_pkg::PH_TEST,
         gfp_pkg::PH_CR, gfp_pkg::PH_NDS, gfp_pkg::PH_CNT: begin
            if (c == 8'd0) begin
               if (phase_ff != gfp_pkg::PH_TEST && phase_ff != gfp_pkg::PH_NDS
                   && b == 8'd2) begin
                  len_in = 8'd2;
               end else begin
                  len_in = 8'd1;
               end
               asm_in   = '0;
               count_in = 8'd1;
            end else if (c <= len_ff) begin
               asm_in = {32'd0, int_word};
               if (c == len_ff) begin
                  case (phase_ff)
                     gfp_pkg::PH_TAL:  rec.rsp.field_code = gfp_pkg::FC_TAL;
                     gfp_pkg::PH_ST:   rec.rsp.field_code = gfp_pkg::FC_STNUM;
                     gfp_pkg::PH_SQ:   rec.rsp.field_code = gfp_pkg::FC_SQNUM;
                     gfp_pkg::PH_TEST: rec.rsp.field_code = gfp_pkg::FC_TEST;
                     gfp_pkg::PH_CR:   rec.rsp.field_code = gfp_pkg::FC_CONFREV;
                     gfp_pkg::PH_NDS:  rec.rsp.field_code = gfp_pkg::FC_NDSCOM;
                     default: begin
                        rec.rsp.field_code = gfp_pkg::FC_ENT_CNT;
                        expect_in = int_word;
                     end
                  endcase
                  rec.rsp.field_value = {46'd0, int_word};
                  emit = 1'b1;
               end
               count_in = c_next[7:0];
            end else begin
               count_in = '0;
               phase_in = gfp_pkg::phase_type'(phase_ff + 5'd1);
            end
         end
         gfp_pkg::PH_ENT_TYPE: begin
            rec.rsp.field_code   = gfp_pkg::FC_ENT_TYPE;
            rec.rsp.field_value  = {54'd0, b};
            rec.rsp.entry_number = entry_ff;
            emit = 1'b1;
            phase_in = gfp_pkg::PH_ENT_SIZE;
         end
         gfp_pkg::PH_ENT_SIZE: begin
            rec.rsp.field_code   = gfp_pkg::FC_ENT_SIZE;
            rec.rsp.field_value  = {54'd0, b};
            rec.rsp.entry_number = entry_ff;
            emit = 1'b1;
            len_in   = b;
            count_in = '0;
            if (b == 8'd0) begin
               entry_in = entry_inc;
               if (entry_inc >= expect_ff) begin
                  done_in  = 1'b1;
                  phase_in = gfp_pkg::PH_DONE;
               end else begin
                  phase_in = gfp_pkg::PH_ENT_TYPE;
               end
            end else begin
               phase_in = gfp_pkg::PH_ENT_DATA;
            end
         end
         gfp_pkg::PH_ENT_DATA: begin
            rec.rsp.field_code   = gfp_pkg::FC_ENT_BYTE;
            rec.rsp.field_value  = {54'd0, b};
            rec.rsp.entry_number = entry_ff;
            rec.rsp.byte_number  = c;
            emit = 1'b1;
            count_in = c_next[7:0];
            if (c_next >= {1'b0, len_ff}) begin
               count_in = '0;
               entry_in = entry_inc;
               if (entry_inc >= expect_ff) begin
                  done_in  = 1'b1;
                  phase_in = gfp_pkg::PH_DONE;
               end else begin
                  phase_in = gfp_pkg::PH_ENT_TYPE;
               end
            end
         end
         default: begin
            phase_in = gfp_pkg::PH_DONE;
         end
      endcase
      rec.rsp.frame_end      = byte_data.frame_last;
      rec.rsp.parse_complete = byte_data.frame_last & done_in;
      rec_push = byte_valid & (emit | byte_data.frame_last);
   end

   always_ff @(posedge clock) begin
      if (reset || (byte_valid && byte_data.frame_last)) begin
         phase_ff  <= gfp_pkg::PH_HDR;
         count_ff  <= '0;
         len_ff    <= '0;
         asm_ff    <= '0;
         secs_ff   <= '0;
         frac_ff   <= '0;
         expect_ff <= '0;
         entry_ff  <= '0;
         done_ff   <= 1'b0;
      end else if (byte_valid) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         len_ff    <= len_in;
         asm_ff    <= asm_in;
         secs_ff   <= secs_in;
         frac_ff   <= frac_in;
         expect_ff <= expect_in;
         entry_ff  <= entry_in;
         done_ff   <= done_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/gfp_queue.sv =====
// Short record queue between the classifier and the value pipeline.
`default_nettype none
module gfp_queue #(
   parameter int Depth = gfp_pkg::QueueDepth
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  gfp_pkg::rec_type  push_data,
   output logic              full,
   input  wire               pop,
   output logic              pop_valid,
   output gfp_pkg::rec_type  pop_data
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   gfp_pkg::rec_type slots_ff [Depth];
   logic [PtrW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full      = (cnt_ff == CntW'(Depth));
   assign pop_valid = (cnt_ff != '0);
   assign pop_data  = slots_ff[rd_ff];
   assign do_push   = push & ~full;
   assign do_pop    = pop & pop_valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PtrW'(Depth - 1)) ? '0 : wr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PtrW'(Depth - 1)) ? '0 : rd_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         slots_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== src/gfp_back.sv =====
// Two-stage value pipeline that scales the GOOSE timestamp to nanoseconds.
`default_nettype none
module gfp_back (
   input  wire               clock,
   input  wire               reset,
   input  wire               rec_valid,
   input  gfp_pkg::rec_type  rec,
   output logic              rec_pop,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output gfp_pkg::rsp_type  rsp_data
);

   logic             a_v_ff, a_v_in;
   gfp_pkg::rec_type a_rec_ff;
   logic [61:0]      prod_s_ff, prod_f_ff;
   logic             o_v_ff, o_v_in;
   gfp_pkg::rsp_type o_ff, o_in;
   logic             adv_a, adv_b;

   assign adv_b   = ~o_v_ff | rsp_ready;
   assign adv_a   = ~a_v_ff | adv_b;
   assign rec_pop = adv_a;
   assign a_v_in  = adv_a ? rec_valid : a_v_ff;
   assign o_v_in  = adv_b ? a_v_ff : o_v_ff;

   always_comb begin
      o_in = a_rec_ff.rsp;
      if (a_rec_ff.is_time) begin
         o_in.field_value = prod_s_ff + {32'd0, prod_f_ff[61:32]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else begin
         a_v_ff <= a_v_in;
         o_v_ff <= o_v_in;
      end
      if (adv_a) begin
         a_rec_ff  <= rec;
         prod_s_ff <= {30'd0, rec.seconds} * {32'd0, gfp_pkg::NsPerSec};
         prod_f_ff <= {30'd0, rec.fraction} * {32'd0, gfp_pkg::NsPerSec};
      end
      if (adv_b) begin
         o_ff <= o_in;
      end
   end

   assign rsp_valid = o_v_ff;
   assign rsp_data  = o_ff;

endmodule
`default_nettype wire

// ===== src/goose_frame_parser.sv =====
// Top level of the GOOSE frame parser: classifier, record queue and value pipeline.
//
//  Channel  Direction  Handshake               Payload
//  req      in         req_valid / req_ready   gfp_pkg::req_type (frame byte, last flag)
//  rsp      out        rsp_valid / rsp_ready   gfp_pkg::rsp_type (one decoded field)
//
// One frame byte is accepted per cycle while the record queue has room.
// After its byte is accepted, a result passes the queue, the multiply register and the add register.
// The timestamp path uses two 32 by 30 bit multipliers followed by one 62-bit add.
// Reset is synchronous; the last byte of a frame returns the parser to the start.
// A stalled result holds the pipeline; bytes keep flowing until the queue fills.
`default_nettype none
module goose_frame_parser #(
   parameter int QueueDepth = gfp_pkg::QueueDepth
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  gfp_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output gfp_pkg::rsp_type  rsp_data
);

   gfp_pkg::rec_type f_rec, q_rec;
   logic f_push, q_full, q_valid, q_pop;

   assign req_ready = ~q_full;

   gfp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_valid & req_ready),
      .byte_data  (req_data),
      .rec        (f_rec),
      .rec_push   (f_push)
   );

   gfp_queue #(.Depth(QueueDepth)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data (f_rec),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_rec)
   );

   gfp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rec_valid (q_valid),
      .rec       (q_rec),
      .rec_pop   (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== src/gfp_checker.sv =====
// Port-level assertions for the GOOSE frame parser and their binding.
`default_nettype none
module gfp_checker (
   input wire              clock,
   input wire              reset,
   input wire              rsp_valid,
   input wire              rsp_ready,
   input gfp_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("Result item changed while stalled.");

   a_complete_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.parse_complete |-> rsp_data.frame_end)
      else $error("Completion flagged on an item that does not end a frame.");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.field_code <= gfp_pkg::FC_MAX)
      else $error("Field code out of range.");

   a_byte_num: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.byte_number != 8'd0 |->
         rsp_data.field_code == gfp_pkg::FC_GOCB_CHR ||
         rsp_data.field_code == gfp_pkg::FC_DS_CHR ||
         rsp_data.field_code == gfp_pkg::FC_GOID_CHR ||
         rsp_data.field_code == gfp_pkg::FC_ENT_BYTE)
      else $error("Byte number on a field without characters.");

   a_entry_num: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.entry_number != 16'd0 |->
         rsp_data.field_code == gfp_pkg::FC_ENT_TYPE ||
         rsp_data.field_code == gfp_pkg::FC_ENT_SIZE ||
         rsp_data.field_code == gfp_pkg::FC_ENT_BYTE)
      else $error("Entry number on a field outside the dataset.");

endmodule

bind goose_frame_parser gfp_checker u_gfp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire
